/* rtl/ftqg_pkg.sv */
// Package for the frame time quality governor: widths, register and mode codes,
// and the structs passed between the configuration block, the core and the top level.
// Depends on nothing.
package ftqg_pkg;

	localparam int WINDOW_FRAMES = 30;
	localparam int IDX_W = $clog2(WINDOW_FRAMES);
	localparam int CNT_W = $clog2(WINDOW_FRAMES + 1);
	localparam int TS_W = 32;
	localparam int SUM_W = 37;
	localparam int COOL_W = 8;
	localparam int MODE_W = 2;
	localparam int REG_IDX_W = 2;

	localparam logic [TS_W-1:0] DOWN_RESET = 32'd33000;
	localparam logic [TS_W-1:0] UP_RESET = 32'd20000;
	localparam logic [COOL_W-1:0] COOL_RESET = 8'd60;

	localparam logic [REG_IDX_W-1:0] REG_DOWNGRADE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_UPGRADE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 2'd2;

	localparam logic [MODE_W-1:0] MODE_STANDARD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW_POLY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BILLBOARD = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] hi_sum;
		logic [SUM_W-1:0] lo_sum;
		logic [COOL_W-1:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic [TS_W-1:0] now_us;
		logic [TS_W-1:0] atom_count;
		logic [MODE_W-1:0] current_mode;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] new_mode;
		logic mode_changed;
		logic window_evaluated;
		logic [SUM_W-1:0] window_sum;
	} res_t;

endpackage

/* rtl/ftqg_ifs.sv */
// Channel interfaces of the frame time quality governor: input items, results and
// configuration writes. Depends on ftqg_pkg.
interface ftqg_in_if;
	logic valid;
	logic ready;
	logic [ftqg_pkg::TS_W-1:0] now_us;
	logic [ftqg_pkg::TS_W-1:0] atom_count;
	logic [ftqg_pkg::MODE_W-1:0] current_mode;
	modport source (output valid, now_us, atom_count, current_mode, input ready);
	modport sink (input valid, now_us, atom_count, current_mode, output ready);
endinterface

interface ftqg_out_if;
	logic valid;
	logic ready;
	logic [ftqg_pkg::MODE_W-1:0] new_mode;
	logic mode_changed;
	logic window_evaluated;
	logic [ftqg_pkg::SUM_W-1:0] window_sum;
	modport source (output valid, new_mode, mode_changed, window_evaluated, window_sum,
		input ready);
	modport sink (input valid, new_mode, mode_changed, window_evaluated, window_sum,
		output ready);
endinterface

interface ftqg_cfg_if;
	logic valid;
	logic ready;
	logic [ftqg_pkg::REG_IDX_W-1:0] index;
	logic [ftqg_pkg::TS_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ftqg_cfg.sv */
// Configuration registers of the frame time quality governor. Thresholds are kept
// pre-scaled by the window length. Depends on ftqg_pkg and ftqg_ifs.
module ftqg_cfg (
	input  logic             clk,
	input  logic             arst_n,
	ftqg_cfg_if.sink         cfg,
	output ftqg_pkg::cfg_t   cfg_o
);

	ftqg_pkg::cfg_t cfg_q;
	logic [ftqg_pkg::SUM_W-1:0] scaled;

	assign cfg.ready = 1'b1;
	assign scaled = ftqg_pkg::SUM_W'(ftqg_pkg::WINDOW_FRAMES)
		* {{(ftqg_pkg::SUM_W - ftqg_pkg::TS_W){1'b0}}, cfg.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hi_sum <= ftqg_pkg::SUM_W'(ftqg_pkg::WINDOW_FRAMES)
				* ftqg_pkg::SUM_W'(ftqg_pkg::DOWN_RESET);
			cfg_q.lo_sum <= ftqg_pkg::SUM_W'(ftqg_pkg::WINDOW_FRAMES)
				* ftqg_pkg::SUM_W'(ftqg_pkg::UP_RESET);
			cfg_q.cooldown <= ftqg_pkg::COOL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ftqg_pkg::REG_DOWNGRADE: cfg_q.hi_sum <= scaled;
				ftqg_pkg::REG_UPGRADE:   cfg_q.lo_sum <= scaled;
				ftqg_pkg::REG_COOLDOWN:  cfg_q.cooldown <= cfg.data[ftqg_pkg::COOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_o = cfg_q;

endmodule

/* rtl/ftqg_core.sv */
// Window core of the frame time quality governor: frame time memory, window state
// and the decision logic. Depends on ftqg_pkg.
module ftqg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ftqg_pkg::cfg_t    cfg_i,
	input  logic              acc,
	input  ftqg_pkg::item_t   item_i,
	input  logic              adv,
	output logic              s1_valid,
	output ftqg_pkg::res_t    res_o
);

	localparam int IW = ftqg_pkg::IDX_W;
	localparam int CW = ftqg_pkg::CNT_W;
	localparam int SW = ftqg_pkg::SUM_W;
	localparam int TW = ftqg_pkg::TS_W;

	logic [TW-1:0] mem [ftqg_pkg::WINDOW_FRAMES];
	logic [TW-1:0] rd_q;

	ftqg_pkg::item_t item_s1;
	logic            valid_s1;

	logic [SW-1:0] sum_q, sum_d;
	logic [IW-1:0] wi_q, wi_d;
	logic [CW-1:0] sc_q, sc_d;
	logic [ftqg_pkg::COOL_W-1:0] cd_q, cd_d;
	logic [TW-1:0] ts_q, wl_q;
	logic started_q;

	logic [TW-1:0] delta;
	logic [SW-1:0] sum_sub, sum_add;
	logic [CW-1:0] sc_inc;
	logic [IW:0] wi_p1;
	logic [IW-1:0] wi_inc, raddr;
	logic full, full_after, we, clear;
	logic [ftqg_pkg::MODE_W-1:0] mode, next_mode;

	assign mode = item_s1.current_mode;
	assign delta = item_s1.now_us - ts_q;
	assign full = sc_q >= CW'(ftqg_pkg::WINDOW_FRAMES);
	assign sum_sub = full ? sum_q - {{(SW - TW){1'b0}}, rd_q} : sum_q;
	assign sum_add = sum_sub + {{(SW - TW){1'b0}}, delta};
	assign sc_inc = full ? sc_q : sc_q + CW'(1);
	assign full_after = sc_inc >= CW'(ftqg_pkg::WINDOW_FRAMES);
	assign wi_p1 = {1'b0, wi_q} + (IW + 1)'(1);
	assign wi_inc = (wi_p1 >= (IW + 1)'(ftqg_pkg::WINDOW_FRAMES)) ? '0 : wi_p1[IW-1:0];

	always_comb begin
		sum_d = sum_q;
		wi_d = wi_q;
		sc_d = sc_q;
		cd_d = cd_q;
		we = 1'b0;
		clear = 1'b0;
		next_mode = mode;
		res_o.window_evaluated = 1'b0;
		res_o.window_sum = '0;
		if (started_q) begin
			if (item_s1.atom_count != wl_q) begin
				clear = 1'b1;
			end else begin
				we = 1'b1;
				sum_d = sum_add;
				sc_d = sc_inc;
				wi_d = wi_inc;
				if (cd_q != '0) begin
					cd_d = cd_q - 8'd1;
				end else if (full_after) begin
					res_o.window_evaluated = 1'b1;
					res_o.window_sum = sum_add;
					if (sum_add > cfg_i.hi_sum) begin
						if (mode == ftqg_pkg::MODE_STANDARD || mode == ftqg_pkg::MODE_LOW_POLY)
							next_mode = mode + 2'd1;
					end else if (sum_add < cfg_i.lo_sum) begin
						if (mode == ftqg_pkg::MODE_LOW_POLY || mode == ftqg_pkg::MODE_BILLBOARD)
							next_mode = mode - 2'd1;
					end
					clear = next_mode != mode;
				end
			end
		end
		if (clear) begin
			sum_d = '0;
			wi_d = '0;
			sc_d = '0;
			cd_d = cfg_i.cooldown;
		end
		res_o.new_mode = next_mode;
		res_o.mode_changed = next_mode != mode;
	end

	// A following item reads at the index this one leaves behind.
	assign raddr = adv ? wi_d : wi_q;

	always_ff @(posedge clk) begin
		if (adv && we)
			mem[wi_q] <= delta;
		if (acc)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (acc)
			item_s1 <= item_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_q <= '0;
			wi_q <= '0;
			sc_q <= '0;
			cd_q <= '0;
			ts_q <= '0;
			wl_q <= '0;
			started_q <= 1'b0;
		end else begin
			if (acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				sum_q <= sum_d;
				wi_q <= wi_d;
				sc_q <= sc_d;
				cd_q <= cd_d;
				ts_q <= item_s1.now_us;
				wl_q <= item_s1.atom_count;
				started_q <= 1'b1;
			end
		end
	end

	assign s1_valid = valid_s1;

endmodule

/* rtl/frame_time_quality_governor.sv */
// Top level of the frame time quality governor: handshake control and output register.
// Depends on ftqg_pkg, ftqg_ifs, ftqg_cfg and ftqg_core.
//
// Usage. One item is sent per rendered frame on din: the microsecond timestamp, the
// workload count and the quality level now in use. For every item exactly one result
// comes back on dout, in order: the level to use next, whether it changed, whether the
// full window was compared and, if so, the window sum.
// Configuration writes arrive on cfg and are always taken (ready is tied high); they
// are expected only while no item is in flight.
// Pipeline. An item transferred on din is registered in the compute stage and its result
// is loaded into the output register when that stage advances. A new item may be
// transferred every cycle while dout is not stalled: the following item reads the frame
// time memory at the index the current item leaves behind, which the core forwards to
// the read port, so the read-modify-write of the window store does not limit the rate.
// Stalls. When dout is not taken the output register holds its result; one more item
// may sit in the compute stage, after which din ready falls until dout moves again.
// Reset. arst_n clears all window state and the handshake flags and restores the
// default thresholds (33000 us down, 20000 us up, 60 frames of cooldown). The frame time
// memory itself is not cleared: an entry is always written before it is read.
module frame_time_quality_governor (
	input  logic        clk,
	input  logic        arst_n,
	ftqg_in_if.sink     din,
	ftqg_out_if.source  dout,
	ftqg_cfg_if.sink    cfg
);

	ftqg_pkg::cfg_t  cfg_w;
	ftqg_pkg::item_t item_w;
	ftqg_pkg::res_t  res_w;
	ftqg_pkg::res_t  res_q;
	logic            o_valid_q;
	logic            s1_valid;
	logic            adv;
	logic            acc;

	ftqg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_w)
	);

	assign item_w.now_us = din.now_us;
	assign item_w.atom_count = din.atom_count;
	assign item_w.current_mode = din.current_mode;

	// The compute stage moves on whenever the output register is free or being emptied.
	assign adv = s1_valid && (!o_valid_q || dout.ready);
	assign din.ready = !s1_valid || adv;
	assign acc = din.valid && din.ready;

	ftqg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_i    (cfg_w),
		.acc      (acc),
		.item_i   (item_w),
		.adv      (adv),
		.s1_valid (s1_valid),
		.res_o    (res_w)
	);

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (adv) begin
			o_valid_q <= 1'b1;
		end else if (dout.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	assign dout.valid = o_valid_q;
	assign dout.new_mode = res_q.new_mode;
	assign dout.mode_changed = res_q.mode_changed;
	assign dout.window_evaluated = res_q.window_evaluated;
	assign dout.window_sum = res_q.window_sum;

endmodule

/* rtl/ftqg_checker.sv */
// Port-level checks for the frame time quality governor and the bind that attaches
// them to the top level. Depends on ftqg_pkg and frame_time_quality_governor.
module ftqg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ftqg_pkg::MODE_W-1:0]  new_mode,
	input logic                         mode_changed,
	input logic                         window_evaluated,
	input logic [ftqg_pkg::SUM_W-1:0]   window_sum
);

	// A switch of quality only ever follows a comparison of the full window.
	a_change_needs_eval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed |-> window_evaluated)
		else $error("mode change without window evaluation");

	// The sum is reported only when the window was compared.
	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_evaluated |-> window_sum == '0)
		else $error("window sum shown without evaluation");

	// The unused level is never switched to.
	a_no_level3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed |-> new_mode != 2'd3)
		else $error("switch to unused quality level");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_mode)
			&& $stable(mode_changed) && $stable(window_evaluated) && $stable(window_sum))
		else $error("stalled result changed");

endmodule

bind frame_time_quality_governor ftqg_checker u_ftqg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (dout.valid),
	.out_ready        (dout.ready),
	.new_mode         (dout.new_mode),
	.mode_changed     (dout.mode_changed),
	.window_evaluated (dout.window_evaluated),
	.window_sum       (dout.window_sum)
);
